@@ src/chd_pkg.sv @@
package chd_pkg;

  localparam int AlphaSize = 256;
  localparam int SymW      = 8;
  localparam int MaxLen    = 15;
  localparam int LenW      = 4;
  localparam int CntW      = 9;
  localparam int CodeW     = 16;
  localparam int TotW      = 16;
  localparam int IdxW      = 9;
  localparam int WinW      = 16;
  localparam int AvailW    = 8;

  typedef enum logic [2:0] {
    StSymbol      = 3'd0,
    StNeedInput   = 3'd1,
    StInvalidCode = 3'd2,
    StInvalidArg  = 3'd3,
    StBuilt       = 3'd4,
    StOversub     = 3'd5,
    StEmptyRej    = 3'd6
  } status_e;

  typedef enum logic {
    KindDecode = 1'b0,
    KindBuild  = 1'b1
  } kind_e;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpDecode = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    BIdle,
    BCount,
    BKraft,
    BFill
  } build_state_e;

  typedef enum logic [1:0] {
    DIdle,
    DWalk,
    DSym
  } dec_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [SymW-1:0]   sym;
    logic [LenW-1:0]   used;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic                           valid;
    logic [TotW-1:0]                total;
    logic [MaxLen:0][CntW-1:0]      count;
    logic [MaxLen:0][CodeW-1:0]     first_code;
    logic [MaxLen:0][CntW-1:0]      first_rank;
  } table_t;

  typedef struct packed {
    logic            we;
    logic [SymW-1:0] addr;
    logic [SymW-1:0] data;
  } sym_wr_t;

endpackage

@@ src/chd_if.sv @@
interface chd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  symbol_index;
  logic [3:0]  code_length;
  logic        last_length;
  logic [15:0] code_bits;
  logic [7:0]  bits_available;

  modport source (
    output valid, opcode, symbol_index, code_length, last_length, code_bits,
           bits_available,
    input  ready
  );
  modport sink (
    input  valid, opcode, symbol_index, code_length, last_length, code_bits,
           bits_available,
    output ready
  );
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] symbol_out;
  logic [3:0] bits_used;
  logic [2:0] status;

  modport source (
    output valid, result_kind, symbol_out, bits_used, status,
    input  ready
  );
  modport sink (
    input  valid, result_kind, symbol_out, bits_used, status,
    output ready
  );
endinterface

@@ src/canonical_huffman_decoder.sv @@
// canonical huffman decoder, lsb-first code words. load words store one code
// length per symbol; the load word marked last starts a table build that
// walks the length memory twice, once to count lengths and once to place
// symbols by rank, with fifteen kraft / first-code steps in between. when the
// set is oversubscribed or rejected as empty, the build ends in the kraft
// steps and the previous table stays in use. a decode word walks one code
// length per cycle through a shared compare unit until a symbol is found, the
// bits run out (need_input) or the code is invalid; a found symbol passes one
// extra state for the symbol memory read, and a rejected argument or an empty
// window is answered from idle without a walk. the block takes one word at a
// time; the input is ready when no work is in flight and the output register
// is empty
module canonical_huffman_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);
  import chd_pkg::*;

  logic    empty_allowed_q;
  logic    busy_q;
  logic    out_valid_q;
  result_t out_q;

  logic    accept;
  logic    is_load;
  logic    build_start;
  logic    dec_start;

  table_t  tbl;
  sym_wr_t sym_wr;
  logic    build_done;
  status_e build_status;
  logic    dec_done;
  result_t dec_result;

  // accept only when idle and nothing waits at the output
  assign in_i.ready  = !busy_q && !out_valid_q;
  assign accept      = in_i.valid && in_i.ready;
  assign is_load     = (in_i.opcode == OpLoad);
  assign build_start = accept && is_load && in_i.last_length;
  assign dec_start   = accept && !is_load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_allowed_q <= 1'b0;
    end else if (cfg_we_i) begin
      empty_allowed_q <= cfg_wdata_i;
    end
  end

  // table builder: owns the length memory and the per-length tables
  chd_build u_build (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .len_we_i        (accept && is_load),
    .len_addr_i      (in_i.symbol_index),
    .len_data_i      (in_i.code_length),
    .start_i         (build_start),
    .empty_allowed_i (empty_allowed_q),
    .tbl_o           (tbl),
    .sym_wr_o        (sym_wr),
    .done_o          (build_done),
    .status_o        (build_status)
  );

  // decoder: owns the rank-to-symbol memory
  chd_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (dec_start),
    .code_bits_i      (in_i.code_bits),
    .bits_available_i (in_i.bits_available),
    .tbl_i            (tbl),
    .sym_wr_i         (sym_wr),
    .done_o           (dec_done),
    .result_o         (dec_result)
  );

  // busy from start of a build or decode until its result lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (build_start || dec_start) begin
        busy_q <= 1'b1;
      end else if (build_done || dec_done) begin
        busy_q <= 1'b0;
      end
      if (build_done || dec_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (build_done) begin
      out_q <= '{kind: KindBuild, sym: '0, used: '0, status: build_status};
    end else if (dec_done) begin
      out_q <= dec_result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_q.kind;
  assign out_o.symbol_out  = out_q.sym;
  assign out_o.bits_used   = out_q.used;
  assign out_o.status      = out_q.status;

endmodule

@@ src/chd_build.sv @@
module chd_build (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           len_we_i,
  input  logic [chd_pkg::SymW-1:0]       len_addr_i,
  input  logic [chd_pkg::LenW-1:0]       len_data_i,
  input  logic                           start_i,
  input  logic                           empty_allowed_i,
  output chd_pkg::table_t                tbl_o,
  output chd_pkg::sym_wr_t               sym_wr_o,
  output logic                           done_o,
  output chd_pkg::status_e               status_o
);
  import chd_pkg::*;

  logic [LenW-1:0] lens_mem [AlphaSize];

  build_state_e state_q, state_d;
  logic [IdxW-1:0]            idx_q;
  logic                       pend_q;
  logic [SymW-1:0]            sidx_q;
  logic [LenW-1:0]            rdata_q;
  logic [MaxLen:0][CntW-1:0]  cnt_q;
  logic                       used_q;
  logic [LenW-1:0]            len_q;
  logic signed [17:0]         left_q;
  logic [CodeW-1:0]           code_q;
  logic [CntW-1:0]            rank_q;
  logic [TotW-1:0]            total_q;
  logic [MaxLen:0][CodeW-1:0] fc_q;
  logic [MaxLen:0][CntW-1:0]  fr_q;
  logic [MaxLen:0][CntW-1:0]  next_rank_q;
  table_t                     tbl_q;
  logic                       done_q;
  status_e                    status_q;

  logic signed [17:0]         left_n;
  logic [CodeW-1:0]           code_n;
  logic [TotW-1:0]            tot_n;
  logic [MaxLen:0][CodeW-1:0] fc_full;
  logic [MaxLen:0][CntW-1:0]  fr_full;
  logic                       pass_end;
  logic                       neg;
  logic                       reject_empty;

  // length store: one write port for loads, one registered read port for the passes
  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      lens_mem[len_addr_i] <= len_data_i;
    end
    rdata_q <= lens_mem[idx_q[SymW-1:0]];
  end

  // one kraft / canonical-code step per length
  always_comb begin
    left_n  = (left_q <<< 1) - $signed({9'd0, cnt_q[len_q]});
    code_n  = CodeW'((code_q + CodeW'(cnt_q[len_q - 4'd1])) << 1);
    tot_n   = total_q + TotW'(TotW'(cnt_q[len_q]) << (4'(MaxLen) - len_q));
    fc_full = fc_q;
    fc_full[len_q] = code_n;
    fr_full = fr_q;
    fr_full[len_q] = rank_q;
    neg          = left_n[17];
    reject_empty = !used_q && !empty_allowed_i;
    pass_end     = idx_q[IdxW-1] && !pend_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BIdle:  if (start_i) state_d = BCount;
      BCount: if (pass_end) state_d = BKraft;
      BKraft: begin
        if (neg) begin
          state_d = BIdle;
        end else if (len_q == 4'(MaxLen)) begin
          state_d = reject_empty ? BIdle : BFill;
        end
      end
      BFill:  if (pass_end) state_d = BIdle;
      default: state_d = BIdle;
    endcase
  end

  always_comb begin
    sym_wr_o.we   = (state_q == BFill) && pend_q && (rdata_q != '0);
    sym_wr_o.addr = next_rank_q[rdata_q][SymW-1:0];
    sym_wr_o.data = sidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BIdle;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      tbl_q    <= '0;
      done_q   <= 1'b0;
      status_q <= StBuilt;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        BIdle: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
        end
        BCount, BFill: begin
          pend_q <= !idx_q[IdxW-1];
          if (!idx_q[IdxW-1]) idx_q <= idx_q + 1'b1;
          if (pass_end) begin
            idx_q <= '0;
            if (state_q == BFill) begin
              done_q   <= 1'b1;
              status_q <= StBuilt;
            end
          end
        end
        BKraft: begin
          if (neg) begin
            done_q   <= 1'b1;
            status_q <= StOversub;
          end else if (len_q == 4'(MaxLen) && reject_empty) begin
            done_q   <= 1'b1;
            status_q <= StEmptyRej;
          end else if (len_q == 4'(MaxLen)) begin
            tbl_q.valid      <= 1'b1;
            tbl_q.total      <= tot_n;
            tbl_q.count      <= cnt_q;
            tbl_q.first_code <= fc_full;
            tbl_q.first_rank <= fr_full;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      BIdle: begin
        cnt_q   <= '0;
        used_q  <= 1'b0;
        fc_q    <= '0;
        fr_q    <= '0;
        len_q   <= 4'd1;
        left_q  <= 18'sd1;
        code_q  <= '0;
        rank_q  <= '0;
        total_q <= '0;
      end
      BCount: begin
        if (pend_q && rdata_q != '0) begin
          cnt_q[rdata_q] <= cnt_q[rdata_q] + 1'b1;
          used_q         <= 1'b1;
        end
      end
      BKraft: begin
        left_q  <= left_n;
        code_q  <= code_n;
        rank_q  <= rank_q + cnt_q[len_q];
        total_q <= tot_n;
        fc_q    <= fc_full;
        fr_q    <= fr_full;
        len_q   <= len_q + 1'b1;
        next_rank_q <= fr_full;
      end
      BFill: begin
        sidx_q <= idx_q[SymW-1:0];
        if (pend_q && rdata_q != '0) begin
          next_rank_q[rdata_q] <= next_rank_q[rdata_q] + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign tbl_o    = tbl_q;
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

@@ src/chd_decode.sv @@
module chd_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [chd_pkg::WinW-1:0]     code_bits_i,
  input  logic [chd_pkg::AvailW-1:0]   bits_available_i,
  input  chd_pkg::table_t              tbl_i,
  input  chd_pkg::sym_wr_t             sym_wr_i,
  output logic                         done_o,
  output chd_pkg::result_t             result_o
);
  import chd_pkg::*;

  logic [SymW-1:0] sym_mem [AlphaSize];

  dec_state_e state_q, state_d;
  logic [LenW-1:0]   len_q;
  logic [MaxLen-1:0] code_q;
  logic [WinW-1:0]   bits_q;
  logic [LenW-1:0]   avail_q;
  logic [LenW-1:0]   used_q;
  logic [SymW-1:0]   sym_q;
  logic              done_q;
  result_t           res_q;

  logic [MaxLen-1:0] c;
  logic [CodeW-1:0]  first;
  logic [CodeW-1:0]  diff;
  logic              hit;
  logic              over;
  logic [CntW-1:0]   r;
  logic [29:0]       shifted;
  logic              bad_arg;

  // one code length per cycle
  always_comb begin
    c       = {code_q[MaxLen-2:0], bits_q[len_q - 4'd1]};
    first   = tbl_i.first_code[len_q];
    diff    = CodeW'(c) - first;
    hit     = (CodeW'(c) >= first) && (diff < CodeW'(tbl_i.count[len_q]));
    r       = tbl_i.first_rank[len_q] + diff[CntW-1:0];
    shifted = {c, 15'd0} >> len_q;
    over    = shifted >= 30'(tbl_i.total);
    bad_arg = (bits_available_i > AvailW'(MaxLen)) || !tbl_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (sym_wr_i.we) begin
      sym_mem[sym_wr_i.addr] <= sym_wr_i.data;
    end
    sym_q <= sym_mem[r[SymW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIdle: begin
        if (start_i && !bad_arg && bits_available_i != '0) state_d = DWalk;
      end
      DWalk: begin
        if (hit) begin
          state_d = DSym;
        end else if (over || len_q == avail_q) begin
          state_d = DIdle;
        end
      end
      DSym:    state_d = DIdle;
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        DIdle:   done_q <= start_i && (bad_arg || bits_available_i == '0);
        DWalk:   done_q <= !hit && (over || len_q == avail_q);
        DSym:    done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIdle: begin
        bits_q  <= code_bits_i;
        avail_q <= bits_available_i[LenW-1:0];
        len_q   <= 4'd1;
        code_q  <= '0;
        res_q   <= '{kind: KindDecode, sym: '0, used: '0,
                     status: bad_arg ? StInvalidArg : StNeedInput};
      end
      DWalk: begin
        code_q <= c;
        len_q  <= len_q + 1'b1;
        used_q <= len_q;
        if (over) begin
          res_q <= '{kind: KindDecode, sym: '0, used: len_q - 4'd1,
                     status: StInvalidCode};
        end else begin
          res_q <= '{kind: KindDecode, sym: '0, used: avail_q,
                     status: StNeedInput};
        end
      end
      DSym: begin
        res_q <= '{kind: KindDecode, sym: sym_q, used: used_q, status: StSymbol};
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
